// ===== rtl/core/hid_keyboard_mouse_report_builder_assert.svh =====
// assertion helpers used by the report builder rtl (hkb_back)
`ifndef HID_KEYBOARD_MOUSE_REPORT_BUILDER_ASSERT_SVH
`define HID_KEYBOARD_MOUSE_REPORT_BUILDER_ASSERT_SVH

// condition holds at every clock edge out of reset
`define HKB_ASSERT(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("hkb assertion failed");

// antecedent at one edge implies consequent at the next
`define HKB_IMPLY(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hkb implication failed");

`endif

// ===== rtl/core/hkb_pkg.sv =====
`default_nettype none

package hkb_pkg;

  localparam int SlotCount = 6;
  localparam int SlotIdxW  = $clog2(SlotCount);

  localparam logic [7:0] ModFirst = 8'hE0;
  localparam logic [7:0] ModLast  = 8'hE7;
  localparam logic [7:0] NoKey    = 8'h00;

  typedef enum logic [2:0] {
    CMD_KEY    = 3'd0,
    CMD_MOVE   = 3'd1,
    CMD_WHEEL  = 3'd2,
    CMD_BUTTON = 3'd3
  } cmd_e;

  typedef enum logic [2:0] {
    OP_MOD,
    OP_KEY,
    OP_MOVE,
    OP_WHEEL,
    OP_BUTTON
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] key_code;
    logic       pressed;
    logic [7:0] mask;
    logic [7:0] dx;
    logic [7:0] dy;
    logic [7:0] wh;
  } op_t;

  typedef logic [SlotCount-1:0][7:0] slots_t;

  typedef struct packed {
    logic            is_mouse;
    logic [7:0][7:0] bytes;
  } rpt_t;

endpackage

`default_nettype wire

// ===== rtl/core/hkb_front.sv =====
`default_nettype none

module hkb_front (
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [39:0]  s_axis_tdata,
  input  wire logic [2:0]   s_axis_tuser,
  input  wire logic         q_ready_i,
  output logic              q_push_o,
  output hkb_pkg::op_t      q_data_o
);
  import hkb_pkg::*;

  cmd_e       cmd;
  logic [7:0] code;
  logic       keep;

  assign cmd  = cmd_e'(s_axis_tuser);
  assign code = s_axis_tdata[7:0];

  always_comb begin
    q_data_o.op       = OP_KEY;
    q_data_o.key_code = code;
    q_data_o.pressed  = s_axis_tdata[8];
    q_data_o.mask     = 8'h00;
    q_data_o.dx       = s_axis_tdata[19:12];
    q_data_o.dy       = s_axis_tdata[27:20];
    q_data_o.wh       = s_axis_tdata[35:28];
    keep              = 1'b0;
    case (cmd)
      CMD_KEY: begin
        keep = (code != NoKey);
        if (code inside {[ModFirst:ModLast]}) begin
          q_data_o.op   = OP_MOD;
          q_data_o.mask = 8'h01 << code[2:0];
        end
      end
      CMD_MOVE: begin
        q_data_o.op = OP_MOVE;
        keep        = (s_axis_tdata[19:12] != 8'h00) || (s_axis_tdata[27:20] != 8'h00);
      end
      CMD_WHEEL: begin
        q_data_o.op = OP_WHEEL;
        keep        = (s_axis_tdata[35:28] != 8'h00);
      end
      CMD_BUTTON: begin
        q_data_o.op   = OP_BUTTON;
        q_data_o.mask = 8'h01 << s_axis_tdata[11:9];
        keep          = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // dropped events are taken and discarded here
  assign s_axis_tready = q_ready_i;
  assign q_push_o      = s_axis_tvalid && q_ready_i && keep;

endmodule

`default_nettype wire

// ===== rtl/core/hkb_fifo.sv =====
`default_nettype none

module hkb_fifo (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire hkb_pkg::op_t data_i,
  output logic              ready_o,
  input  wire logic         pop_i,
  output logic              valid_o,
  output hkb_pkg::op_t      data_o
);
  import hkb_pkg::*;

  op_t        entries_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hkb_back.sv =====
`default_nettype none
`include "hid_keyboard_mouse_report_builder_assert.svh"

module hkb_back (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         q_valid_i,
  input  wire hkb_pkg::op_t q_data_i,
  output logic              q_pop_o,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [63:0]       m_axis_tdata,
  output logic [0:0]        m_axis_tuser
);
  import hkb_pkg::*;

  logic [7:0]          mod_q, mod_d;
  logic [7:0]          btn_q, btn_d;
  slots_t              slots_q, slots_d;
  rpt_t                rpt_q, rpt_d;
  logic                out_valid_q, out_valid_d;
  logic                emit;
  logic                empty_found, match_found;
  logic [SlotIdxW-1:0] empty_idx, match_idx;

  function automatic logic slots_unique(slots_t s);
    logic ok;
    ok = 1'b1;
    for (int a = 0; a < SlotCount; a++) begin
      for (int b = a + 1; b < SlotCount; b++) begin
        if (s[a] != NoKey && s[a] == s[b]) begin
          ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

  assign q_pop_o = q_valid_i && (!out_valid_q || m_axis_tready);

  // first empty slot and first slot holding the key
  always_comb begin
    empty_found = 1'b0;
    match_found = 1'b0;
    empty_idx   = '0;
    match_idx   = '0;
    for (int j = 0; j < SlotCount; j++) begin
      if (!empty_found && slots_q[j] == NoKey) begin
        empty_found = 1'b1;
        empty_idx   = SlotIdxW'(j);
      end
      if (!match_found && slots_q[j] == q_data_i.key_code) begin
        match_found = 1'b1;
        match_idx   = SlotIdxW'(j);
      end
    end
  end

  always_comb begin
    mod_d   = mod_q;
    btn_d   = btn_q;
    slots_d = slots_q;
    emit    = 1'b0;
    if (q_pop_o) begin
      case (q_data_i.op)
        OP_MOD: begin
          mod_d = q_data_i.pressed ? (mod_q | q_data_i.mask) : (mod_q & ~q_data_i.mask);
          emit  = (mod_d != mod_q);
        end
        OP_KEY: begin
          if (q_data_i.pressed) begin
            if (!match_found && empty_found) begin
              slots_d[empty_idx] = q_data_i.key_code;
              emit               = 1'b1;
            end
          end else if (match_found) begin
            slots_d[match_idx] = NoKey;
            emit               = 1'b1;
          end
        end
        OP_MOVE, OP_WHEEL: begin
          emit = 1'b1;
        end
        OP_BUTTON: begin
          btn_d = q_data_i.pressed ? (btn_q | q_data_i.mask) : (btn_q & ~q_data_i.mask);
          emit  = (btn_d != btn_q);
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  // report packing
  always_comb begin
    rpt_d.is_mouse = 1'b1;
    rpt_d.bytes    = '0;
    rpt_d.bytes[0] = btn_d;
    case (q_data_i.op)
      OP_MOD, OP_KEY: begin
        rpt_d.is_mouse = 1'b0;
        rpt_d.bytes[0] = mod_d;
        for (int j = 0; j < SlotCount; j++) begin
          rpt_d.bytes[j + 2] = slots_d[j];
        end
      end
      OP_MOVE: begin
        rpt_d.bytes[1] = q_data_i.dx;
        rpt_d.bytes[2] = q_data_i.dy;
      end
      OP_WHEEL: begin
        rpt_d.bytes[3] = q_data_i.wh;
      end
      default: begin
        rpt_d.bytes[1] = 8'h00;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (q_pop_o) begin
      out_valid_d = emit;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q       <= 8'h00;
      btn_q       <= 8'h00;
      slots_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mod_q       <= mod_d;
      btn_q       <= btn_d;
      slots_q     <= slots_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && emit) begin
      rpt_q <= rpt_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = rpt_q.bytes;
  assign m_axis_tuser  = rpt_q.is_mouse;

  `HKB_ASSERT(a_slots_unique, clk_i, rst_ni, slots_unique(slots_q))
  `HKB_ASSERT(a_kbd_reserved, clk_i, rst_ni, !(out_valid_q && !rpt_q.is_mouse) || rpt_q.bytes[1] == 8'h00)
  `HKB_ASSERT(a_mouse_tail, clk_i, rst_ni, !(out_valid_q && rpt_q.is_mouse) || rpt_q.bytes[7:4] == 32'h0)
  `HKB_IMPLY(a_emit_shows, clk_i, rst_ni, q_pop_o && emit, out_valid_q)

endmodule

`default_nettype wire

// ===== rtl/core/hid_keyboard_mouse_report_builder.sv =====
`default_nettype none

// HID boot keyboard (six key slots) and relative mouse report builder. Each
// request on the slave side is one event; an 8-byte keyboard or 4-byte mouse
// report (padded to 8 bytes) goes out only when the held state changes or the
// motion is nonzero. Events are classified on entry, dropped ones are taken and
// discarded, and the rest go through a two-entry queue to the state unit. The
// state unit handles one event per cycle while the output is free or drained
// (the six-slot search is done in that cycle) and registers the report, which
// is presented once its event leaves the queue; events can be taken at one per
// cycle while the output is drained.
module hid_keyboard_mouse_report_builder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // key_code[7:0] pressed[8] button_index[11:9] move_x[19:12] move_y[27:20]
  // wheel_steps[35:28] zero[39:36]
  input  wire logic [39:0] s_axis_tdata,
  // cmd[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // byte0[7:0] byte1[15:8] byte2[23:16] byte3[31:24] byte4[39:32]
  // byte5[47:40] byte6[55:48] byte7[63:56]
  output logic [63:0]      m_axis_tdata,
  // report_is_mouse[0]
  output logic [0:0]       m_axis_tuser
);
  import hkb_pkg::*;

  logic q_ready, q_push, q_valid, q_pop;
  op_t  q_in, q_out;

  hkb_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_ready_i     (q_ready),
    .q_push_o      (q_push),
    .q_data_o      (q_in)
  );

  hkb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  hkb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_out),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== tb/hid_report_checker.sv =====
`timescale 1ns / 1ps

module hid_report_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  // key_code[7:0] pressed[8] button_index[11:9] move_x[19:12] move_y[27:20]
  // wheel_steps[35:28] zero[39:36]
  input  wire logic [39:0] s_axis_tdata,
  // cmd[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // byte0[7:0] byte1[15:8] byte2[23:16] byte3[31:24] byte4[39:32]
  // byte5[47:40] byte6[55:48] byte7[63:56]
  input  wire logic [63:0] m_axis_tdata,
  // report_is_mouse[0]
  input  wire logic [0:0]  m_axis_tuser,
  output int               fail_count_o,
  output int               pending_o
);
  import hkb_pkg::*;

  logic [7:0] held_mods;
  slots_t     held_keys;
  logic [7:0] held_buttons;
  rpt_t       expected_reports[$];
  int         mismatch_count = 0;

  assign fail_count_o = mismatch_count;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic rpt_t mouse_report(input logic [7:0] dx, input logic [7:0] dy,
                                        input logic [7:0] wh);
    rpt_t r;
    r          = '0;
    r.is_mouse = 1'b1;
    r.bytes[0] = held_buttons;
    r.bytes[1] = dx;
    r.bytes[2] = dy;
    r.bytes[3] = wh;
    return r;
  endfunction

  function automatic rpt_t keyboard_report();
    rpt_t r;
    r          = '0;
    r.bytes[0] = held_mods;
    for (int j = 0; j < SlotCount; j++) r.bytes[2 + j] = held_keys[j];
    return r;
  endfunction

  task automatic apply_event(input logic [2:0] cmd, input logic [39:0] data,
                             output bit emitted, output rpt_t rpt);
    logic [7:0] code;
    logic [7:0] dx;
    logic [7:0] dy;
    logic [7:0] wh;
    logic [7:0] mask;
    logic [7:0] prior;
    logic       down;
    logic [2:0] bidx;
    int         free_slot;
    int         hit_slot;
    code    = data[7:0];
    down    = data[8];
    bidx    = data[11:9];
    dx      = data[19:12];
    dy      = data[27:20];
    wh      = data[35:28];
    emitted = 1'b0;
    rpt     = '0;
    case (cmd)
      CMD_KEY: begin
        if (code != NoKey) begin
          if (code >= ModFirst && code <= ModLast) begin
            mask      = 8'd1 << (code - ModFirst);
            prior     = held_mods;
            held_mods = down ? (held_mods | mask) : (held_mods & ~mask);
            emitted   = (prior != held_mods);
          end else begin
            free_slot = -1;
            hit_slot  = -1;
            for (int j = 0; j < SlotCount; j++) begin
              if (held_keys[j] == NoKey && free_slot < 0) free_slot = j;
              if (held_keys[j] == code && hit_slot < 0) hit_slot = j;
            end
            if (down && hit_slot < 0 && free_slot >= 0) begin
              held_keys[free_slot] = code;
              emitted = 1'b1;
            end else if (!down && hit_slot >= 0) begin
              held_keys[hit_slot] = NoKey;
              emitted = 1'b1;
            end
          end
          if (emitted) rpt = keyboard_report();
        end
      end
      CMD_MOVE: begin
        if (dx != 8'h00 || dy != 8'h00) begin
          emitted = 1'b1;
          rpt     = mouse_report(dx, dy, 8'h00);
        end
      end
      CMD_WHEEL: begin
        if (wh != 8'h00) begin
          emitted = 1'b1;
          rpt     = mouse_report(8'h00, 8'h00, wh);
        end
      end
      CMD_BUTTON: begin
        mask         = 8'd1 << bidx;
        prior        = held_buttons;
        held_buttons = down ? (held_buttons | mask) : (held_buttons & ~mask);
        if (prior != held_buttons) begin
          emitted = 1'b1;
          rpt     = mouse_report(8'h00, 8'h00, 8'h00);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rpt_t want;
    rpt_t next_rpt;
    bit   emitted;
    if (!rst_ni) begin
      held_mods    = '0;
      held_keys    = '0;
      held_buttons = '0;
      expected_reports.delete();
      pending_o   <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_reports.size() == 0) begin
          report_mismatch($sformatf("report with none expected: mouse %0b data %h",
                                    m_axis_tuser[0], m_axis_tdata));
        end else begin
          want = expected_reports.pop_front();
          if (m_axis_tuser[0] !== want.is_mouse)
            report_mismatch($sformatf("report_is_mouse got %b want %b",
                                      m_axis_tuser[0], want.is_mouse));
          for (int j = 0; j < 8; j++) begin
            if (m_axis_tdata[8*j +: 8] !== want.bytes[j])
              report_mismatch($sformatf("byte%0d got %h want %h",
                                        j, m_axis_tdata[8*j +: 8], want.bytes[j]));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        apply_event(s_axis_tuser, s_axis_tdata, emitted, next_rpt);
        if (emitted) expected_reports.push_back(next_rpt);
      end
      pending_o <= expected_reports.size();
    end
  end

endmodule

// ===== tb/hid_keyboard_mouse_report_builder_test.sv =====
`timescale 1ns / 1ps

module hid_keyboard_mouse_report_builder_test;
  import hkb_pkg::*;

  localparam logic [2:0] CmdUnusedFirst = 3'd4;
  localparam logic [2:0] CmdUnusedLast  = 3'd7;
  localparam int         EventCount     = 1650;
  localparam int         CalmTail       = 150;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  int fail_count;
  int pending;
  bit idle_on;
  int stall_left;

  hid_keyboard_mouse_report_builder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  hid_report_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // report sink with random stall bursts
  initial begin
    m_axis_tready = 1'b0;
    stall_left    = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left    = $urandom_range(1, 14) - 1;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  task automatic send_event(input logic [2:0] cmd, input logic [7:0] code,
                            input logic down, input logic [2:0] bidx,
                            input logic [7:0] dx, input logic [7:0] dy,
                            input logic [7:0] wh);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {4'b0000, wh, dy, dx, bidx, down, code};
    s_axis_tuser  = cmd;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  initial begin : stimulus
    int         effective;
    int         pick;
    logic [2:0] cmd;
    logic [7:0] code;
    logic [7:0] dx;
    logic [7:0] dy;
    logic [7:0] wh;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    idle_on       = 1'b1;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // keycode zero, duplicate press, full slots, stray release
    send_event(CMD_KEY, NoKey, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00);
    send_event(CMD_KEY, 8'h04, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00);
    send_event(CMD_KEY, 8'h04, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00);
    for (int k = 5; k <= 9; k++)
      send_event(CMD_KEY, 8'(k), 1'b1, 3'd0, 8'h00, 8'h00, 8'h00);
    send_event(CMD_KEY, 8'hFF, 1'b1, 3'd7, 8'hFF, 8'hFF, 8'hFF);
    send_event(CMD_KEY, 8'h0A, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00);
    send_event(CMD_KEY, 8'h04, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00);
    send_event(CMD_KEY, NoKey, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00);
    // modifiers at both ends, repeated press
    send_event(CMD_KEY, ModFirst, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00);
    send_event(CMD_KEY, ModFirst, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00);
    send_event(CMD_KEY, ModLast, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00);
    send_event(CMD_KEY, ModLast, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00);
    // motion, zero and extremes
    send_event(CMD_MOVE, 8'h00, 1'b0, 3'd0, 8'h00, 8'h00, 8'h7F);
    send_event(CMD_MOVE, 8'h00, 1'b0, 3'd0, 8'h80, 8'h7F, 8'h00);
    send_event(CMD_MOVE, 8'h00, 1'b0, 3'd0, 8'h00, 8'h80, 8'h00);
    send_event(CMD_WHEEL, 8'h00, 1'b0, 3'd0, 8'h11, 8'h22, 8'h00);
    send_event(CMD_WHEEL, 8'h00, 1'b0, 3'd0, 8'h00, 8'h00, 8'h80);
    send_event(CMD_WHEEL, 8'h00, 1'b0, 3'd0, 8'h00, 8'h00, 8'h7F);
    // buttons at both ends, repeated press
    send_event(CMD_BUTTON, 8'h00, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00);
    send_event(CMD_BUTTON, 8'h00, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00);
    send_event(CMD_BUTTON, 8'h00, 1'b1, 3'd7, 8'h00, 8'h00, 8'h00);
    send_event(CMD_BUTTON, 8'h00, 1'b0, 3'd7, 8'h00, 8'h00, 8'h00);
    send_event(CmdUnusedFirst, 8'h04, 1'b1, 3'd1, 8'h01, 8'h01, 8'h01);
    send_event(CmdUnusedLast, 8'h05, 1'b1, 3'd2, 8'h01, 8'h01, 8'h01);

    effective = 0;
    while (effective < EventCount) begin
      if (effective % 100 == 0)
        idle_on = (effective < EventCount - CalmTail) && ($urandom_range(0, 3) != 0);
      code = 8'($urandom_range(0, 255));
      dx   = 8'($urandom_range(0, 255));
      dy   = 8'($urandom_range(0, 255));
      wh   = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        cmd  = CMD_KEY;
        pick = $urandom_range(0, 9);
        if (pick < 6) code = 8'h04 + 8'($urandom_range(0, 9));
        else if (pick < 8) code = ModFirst + 8'($urandom_range(0, 7));
      end else if (pick < 65) begin
        cmd = CMD_MOVE;
        if ($urandom_range(0, 9) == 0) begin
          dx = 8'h00;
          dy = 8'h00;
        end
      end else if (pick < 75) begin
        cmd = CMD_WHEEL;
        if ($urandom_range(0, 9) == 0) wh = 8'h00;
      end else if (pick < 92) begin
        cmd = CMD_BUTTON;
      end else begin
        cmd = 3'($urandom_range(CmdUnusedFirst, CmdUnusedLast));
      end
      send_event(cmd, code, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), dx, dy, wh);
      effective++;
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    idle_on       = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/hkb_pkg.sv
rtl/core/hkb_front.sv
rtl/core/hkb_fifo.sv
rtl/core/hkb_back.sv
rtl/core/hid_keyboard_mouse_report_builder.sv
tb/hid_report_checker.sv
tb/hid_keyboard_mouse_report_builder_test.sv
